[design/mpc_pkg.sv]
// shared types, constants and fixed-point helpers of the mandelbrot pixel colour unit
`default_nettype none

package mpc_pkg;

  // fixed-point format and sizes
  localparam int FRAC_BITS  = 28;
  localparam int MAX_SIZE   = 4096;
  localparam int PIX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int ITER_W     = 16;
  localparam int COL_W      = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int Q_W        = FRAC_BITS + 4;
  localparam int D_W        = $clog2(MAX_SIZE);
  localparam int QUO_W      = PIX_W + 1 + FRAC_BITS;
  localparam int QUO_CNT_W  = $clog2(QUO_W + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // reset values of the registers
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = SIZE_W'(512);
  localparam logic [ITER_W-1:0] MAX_ITER_RST   = ITER_W'(256);

  // format limits, plain width and two bits of headroom
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W-1:0]        Q_LIM = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W+1:0] Q_ONE_X =
    {{(Q_W+1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [Q_W+1:0] Q_ONE_HALF_X =
    {{(Q_W+2-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [Q_W+1:0] Q_FOUR_X =
    {{(Q_W-1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE     = 1'b0,
    CFG_MAX_ITERATIONS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_FIN
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [PIX_W-1:0] x_pixel;
    logic [PIX_W-1:0] y_pixel;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0]  red;
    logic [COL_W-1:0]  green;
    logic [COL_W-1:0]  blue;
    logic [ITER_W-1:0] iterations_left;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  // point c handed from the front to the back
  typedef struct packed {
    logic signed [Q_W-1:0] cx;
    logic signed [Q_W-1:0] cy;
  } coord_t;

  // palette
  localparam rgb_t RGB_BLACK = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
  localparam rgb_t RGB_PAL_0 = '{red: 8'd188, green: 8'd74,  blue: 8'd82};
  localparam rgb_t RGB_PAL_1 = '{red: 8'd231, green: 8'd112, blue: 8'd82};
  localparam rgb_t RGB_PAL_2 = '{red: 8'd245, green: 8'd163, blue: 8'd97};
  localparam rgb_t RGB_PAL_3 = '{red: 8'd231, green: 8'd196, blue: 8'd107};
  localparam rgb_t RGB_PAL_4 = '{red: 8'd41,  green: 8'd158, blue: 8'd143};

  // clamp a widened value to the fixed-point range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W+1:0] v);
    logic signed [Q_W+1:0] hi;
    logic signed [Q_W+1:0] lo;
    hi = {2'b00, Q_MAX};
    lo = {2'b11, Q_MIN};
    if (v > hi) begin
      sat_q = Q_MAX;
    end else if (v < lo) begin
      sat_q = Q_MIN;
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

  // truncate a magnitude product, apply the sign and clamp
  function automatic logic signed [Q_W-1:0] mul_fix(input logic [2*Q_W-1:0] prod,
                                                    input logic neg);
    logic [2*Q_W-FRAC_BITS-1:0] trunc;
    logic [Q_W-1:0]             mag;
    trunc = prod[2*Q_W-1:FRAC_BITS];
    if (trunc > {{(Q_W-FRAC_BITS){1'b0}}, Q_LIM}) begin
      mag = Q_LIM;
    end else begin
      mag = trunc[Q_W-1:0];
    end
    if (neg) begin
      mul_fix = ~mag + 1'b1;
    end else if (mag[Q_W-1]) begin
      mul_fix = Q_MAX;
    end else begin
      mul_fix = mag;
    end
  endfunction

endpackage

`default_nettype wire

[design/mpc_front.sv]
// front part: accepts a pixel and maps it to the point c with a bit-serial divider
`default_nettype none

module mpc_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  mpc_pkg::pixel_t              pixel_i,
  input  wire [mpc_pkg::SIZE_W-1:0]    image_size_i,
  output logic                         push_o,
  output mpc_pkg::coord_t              coord_o,
  input  wire                          full_i
);
  import mpc_pkg::*;

  front_state_e           state_q, state_d;
  logic [QUO_CNT_W-1:0]   cnt_q;
  logic [D_W-1:0]         div_q;
  logic [QUO_W-1:0]       num_q [2];
  logic [D_W-1:0]         rem_q [2];
  logic [QUO_W-1:0]       num_d [2];
  logic [D_W-1:0]         rem_d [2];
  logic [D_W:0]           trial_c [2];
  logic [D_W:0]           diff_c [2];
  logic [PIX_W-1:0]       pix_c [2];
  logic                   load_c;
  logic                   step_c;
  logic [SIZE_W-1:0]      size_c;
  logic [SIZE_W-1:0]      dsr_c;
  logic                   ovf_c [2];
  logic signed [Q_W+1:0]  quo_x [2];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (start_i) state_d = FR_DIV;
      end
      FR_DIV: begin
        if (cnt_q == QUO_CNT_W'(1)) state_d = FR_FIN;
      end
      FR_FIN: begin
        if (!full_i) state_d = FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy_o = 1'b1;
    load_c = 1'b0;
    step_c = 1'b0;
    push_o = 1'b0;
    case (state_q)
      FR_IDLE: begin
        busy_o = 1'b0;
        load_c = start_i;
      end
      FR_DIV:  step_c = 1'b1;
      FR_FIN:  push_o = !full_i;
      default: busy_o = 1'b1;
    endcase
  end

  // divisor: side clamped to the largest image, minus one, at least one
  always_comb begin
    size_c = (image_size_i > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : image_size_i;
    dsr_c  = (size_c < SIZE_W'(2)) ? SIZE_W'(1) : size_c - SIZE_W'(1);
  end

  // one restoring division step per lane, x and y side by side
  always_comb begin
    pix_c[0] = pixel_i.x_pixel;
    pix_c[1] = pixel_i.y_pixel;
    for (int l = 0; l < 2; l++) begin
      trial_c[l] = {rem_q[l], num_q[l][QUO_W-1]};
      diff_c[l]  = trial_c[l] - {1'b0, div_q};
      if (trial_c[l] >= {1'b0, div_q}) begin
        rem_d[l] = diff_c[l][D_W-1:0];
        num_d[l] = {num_q[l][QUO_W-2:0], 1'b1};
      end else begin
        rem_d[l] = trial_c[l][D_W-1:0];
        num_d[l] = {num_q[l][QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (load_c) begin
        cnt_q <= QUO_CNT_W'(QUO_W);
      end else if (step_c) begin
        cnt_q <= cnt_q - QUO_CNT_W'(1);
      end
    end
  end

  // numerator 2p shifted up by the fraction, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (load_c) begin
      div_q <= dsr_c[D_W-1:0];
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= {pix_c[l], {(FRAC_BITS+1){1'b0}}};
        rem_q[l] <= '0;
      end
    end else if (step_c) begin
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= num_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
  end

  // offset the quotients into c, an integer part of 16 or more pins the result
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf_c[l] = |num_q[l][QUO_W-1:Q_W];
      quo_x[l] = {2'b00, num_q[l][Q_W-1:0]};
    end
    coord_o.cx = ovf_c[0] ? Q_MAX : sat_q(quo_x[0] - Q_ONE_X - Q_ONE_HALF_X);
    coord_o.cy = ovf_c[1] ? Q_MIN : sat_q(Q_ONE_X - quo_x[1]);
  end

endmodule

`default_nettype wire

[design/mpc_queue.sv]
// short queue of points between the front and the back
`default_nettype none

module mpc_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  mpc_pkg::coord_t data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output mpc_pkg::coord_t data_o
);
  import mpc_pkg::*;

  coord_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/mpc_back.sv]
// back part: escape-time iteration of one point and palette lookup
`default_nettype none

module mpc_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          empty_i,
  input  mpc_pkg::coord_t              coord_i,
  output logic                         pop_o,
  input  wire [mpc_pkg::ITER_W-1:0]    max_iterations_i,
  output logic                         result_valid_o,
  output mpc_pkg::result_t             result_o
);
  import mpc_pkg::*;

  localparam int CMP_W = ITER_W + 8;

  back_state_e            state_q, state_d;
  logic signed [Q_W-1:0]  cx_q, cy_q, zx_q, zy_q;
  logic [ITER_W-1:0]      left_q, mx_q;
  logic [2*Q_W-1:0]       prod_xx_q, prod_yy_q, prod_xy_q;
  logic                   neg_xy_q;
  logic                   result_valid_q;
  result_t                result_q;
  logic                   mul_en_c, upd_en_c, done_en_c;
  logic [Q_W-1:0]         mag_x_c, mag_y_c;
  logic signed [Q_W-1:0]  sx_c, sy_c, pxy_c;
  logic signed [Q_W+1:0]  sx_x, sy_x, pxy_x, cx_x, cy_x, sum_x;
  logic                   escape_c;
  logic signed [Q_W-1:0]  zx_next_c, zy_next_c;
  logic [CMP_W-1:0]       l_x, m_x;
  rgb_t                   rgb_c;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) state_d = BK_MUL;
      end
      BK_MUL: begin
        state_d = (left_q == '0) ? BK_DONE : BK_UPD;
      end
      BK_UPD: begin
        state_d = escape_c ? BK_DONE : BK_MUL;
      end
      BK_DONE: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = 1'b0;
    mul_en_c  = 1'b0;
    upd_en_c  = 1'b0;
    done_en_c = 1'b0;
    case (state_q)
      BK_IDLE: pop_o     = !empty_i;
      BK_MUL:  mul_en_c  = (left_q != '0);
      BK_UPD:  upd_en_c  = !escape_c;
      BK_DONE: done_en_c = 1'b1;
      default: pop_o     = 1'b0;
    endcase
  end

  // magnitudes of z for the products
  always_comb begin
    mag_x_c = zx_q[Q_W-1] ? (~zx_q + 1'b1) : zx_q;
    mag_y_c = zy_q[Q_W-1] ? (~zy_q + 1'b1) : zy_q;
  end

  // squares, escape test and next z
  always_comb begin
    sx_c      = mul_fix(prod_xx_q, 1'b0);
    sy_c      = mul_fix(prod_yy_q, 1'b0);
    pxy_c     = mul_fix(prod_xy_q, neg_xy_q);
    sx_x      = {{2{sx_c[Q_W-1]}}, sx_c};
    sy_x      = {{2{sy_c[Q_W-1]}}, sy_c};
    pxy_x     = {{2{pxy_c[Q_W-1]}}, pxy_c};
    cx_x      = {{2{cx_q[Q_W-1]}}, cx_q};
    cy_x      = {{2{cy_q[Q_W-1]}}, cy_q};
    sum_x     = sx_x + sy_x;
    escape_c  = (sum_x >= Q_FOUR_X);
    zx_next_c = sat_q(sx_x - sy_x + cx_x);
    zy_next_c = sat_q((pxy_x <<< 1) + cy_x);
  end

  // palette by ratio of iterations left to budget
  always_comb begin
    l_x = {{(CMP_W-ITER_W){1'b0}}, left_q};
    m_x = {{(CMP_W-ITER_W){1'b0}}, mx_q};
    if (left_q == '0) begin
      rgb_c = RGB_BLACK;
    end else if (CMP_W'(5) * l_x < CMP_W'(3) * m_x) begin
      rgb_c = RGB_PAL_0;
    end else if (CMP_W'(20) * l_x < CMP_W'(17) * m_x) begin
      rgb_c = RGB_PAL_1;
    end else if (CMP_W'(25) * l_x < CMP_W'(23) * m_x) begin
      rgb_c = RGB_PAL_2;
    end else if (CMP_W'(100) * l_x < CMP_W'(97) * m_x) begin
      rgb_c = RGB_PAL_3;
    end else if (left_q < mx_q) begin
      rgb_c = RGB_PAL_4;
    end else begin
      rgb_c = RGB_BLACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= done_en_c;
    end
  end

  // iteration datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cx_q   <= coord_i.cx;
      cy_q   <= coord_i.cy;
      zx_q   <= '0;
      zy_q   <= '0;
      left_q <= max_iterations_i;
      mx_q   <= max_iterations_i;
    end
    if (mul_en_c) begin
      prod_xx_q <= mag_x_c * mag_x_c;
      prod_yy_q <= mag_y_c * mag_y_c;
      prod_xy_q <= mag_x_c * mag_y_c;
      neg_xy_q  <= zx_q[Q_W-1] ^ zy_q[Q_W-1];
    end
    if (upd_en_c) begin
      zx_q   <= zx_next_c;
      zy_q   <= zy_next_c;
      left_q <= left_q - ITER_W'(1);
    end
    if (done_en_c) begin
      result_q.red             <= rgb_c.red;
      result_q.green           <= rgb_c.green;
      result_q.blue            <= rgb_c.blue;
      result_q.iterations_left <= left_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

[design/mandelbrot_pixel_colour_unit.sv]
// top level of the mandelbrot pixel colour unit
//
// Usage: raise start with a pixel on pixel_i; the word is taken at a rising
// edge with start high and busy low. Each pixel gives exactly one result
// word on result_o, shown for one cycle with result_valid_o high; the
// receiver cannot hold results off.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i at a
// rising edge with cfg_we_i high: index 0 is the image side (reset 512),
// index 1 the iteration budget (reset 256). Write them only while no
// pixel is in flight.
// The front divides x and y side by side bit-serially, then hands the
// point to the queue; busy stays high from each accepted word until the
// point is handed over. The back pops the point and iterates: the three
// products (BK_MUL), then the escape test and update (BK_UPD), until the
// point escapes or the budget is spent; BK_DONE then registers the
// palette colour and the iterations left. The back takes the next point
// only once it has registered its result; the slower part sets the
// throughput. A two-entry queue lets the front run ahead, and a finished
// point waits in the front, with busy high, while the queue is full.
// Reset clears the control state and restores both registers; no
// result is shown until a pixel has been taken.
`default_nettype none

module mandelbrot_pixel_colour_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  mpc_pkg::pixel_t                 pixel_i,
  input  wire                             cfg_we_i,
  input  wire [mpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [mpc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                            result_valid_o,
  output mpc_pkg::result_t                result_o
);
  import mpc_pkg::*;

  logic [SIZE_W-1:0] image_size_q;
  logic [ITER_W-1:0] max_iterations_q;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  coord_t            coord_in;
  coord_t            coord_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q     <= IMAGE_SIZE_RST;
      max_iterations_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IMAGE_SIZE:     image_size_q     <= cfg_data_i[SIZE_W-1:0];
        CFG_MAX_ITERATIONS: max_iterations_q <= cfg_data_i[ITER_W-1:0];
        default:            image_size_q     <= image_size_q;
      endcase
    end
  end

  // pixel to point
  mpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .pixel_i      (pixel_i),
    .image_size_i (image_size_q),
    .push_o       (push),
    .coord_o      (coord_in),
    .full_i       (full)
  );

  // points waiting for the back
  mpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (coord_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (coord_out)
  );

  // iteration and colour
  mpc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .coord_i          (coord_out),
    .pop_o            (pop),
    .max_iterations_i (max_iterations_q),
    .result_valid_o   (result_valid_o),
    .result_o         (result_o)
  );

endmodule

`default_nettype wire

[design/mpc_checker.sv]
// port-level checks of the mandelbrot pixel colour unit, bound to the top level
`default_nettype none

module mpc_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             start,
  input wire                             busy,
  input wire                             result_valid_o,
  input mpc_pkg::result_t                result_o
);
  import mpc_pkg::*;

  // a result word is a single-cycle strobe, never two in a row
  property p_strobe_single;
    @(posedge clk_i) disable iff (!rst_ni)
      result_valid_o |=> !result_valid_o;
  endproperty
  a_strobe_single: assert property (p_strobe_single)
    else $error("result strobe held for two cycles");

  // an accepted word makes the front busy
  property p_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (start && !busy) |=> busy;
  endproperty
  a_accept_busy: assert property (p_accept_busy)
    else $error("front not busy after accepting a word");

  // busy only rises after an accepted start
  property p_busy_cause;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(busy) |-> $past(start);
  endproperty
  a_busy_cause: assert property (p_busy_cause)
    else $error("busy rose without a start");

  // a point that never escaped is black
  property p_inside_black;
    @(posedge clk_i) disable iff (!rst_ni)
      (result_valid_o && (result_o.iterations_left == '0)) |->
        (result_o.red == '0) && (result_o.green == '0) && (result_o.blue == '0);
  endproperty
  a_inside_black: assert property (p_inside_black)
    else $error("non-escaping point not black");

endmodule

bind mandelbrot_pixel_colour_unit mpc_checker u_mpc_checker (.*);

`default_nettype wire

[dv/tb.sv]
// testbench of the mandelbrot pixel colour unit: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module tb;
  import mpc_pkg::*;

  typedef logic signed [Q_W-1:0] fix_t;

  localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
  localparam longint FIX_MAX = 8 * FIX_ONE - 1;
  localparam longint FIX_MIN = -8 * FIX_ONE;
  localparam longint unsigned FIX_LIM = longint'(8) * FIX_ONE;
  localparam int STALL_LIMIT = 600_000;

  // expected colours of accepted pixels and the register copies they depend on
  class colour_checker;
    logic [SIZE_W-1:0] image_size;
    logic [ITER_W-1:0] max_iter;
    result_t expected_colours[$];
    int errors;

    function new();
      image_size = IMAGE_SIZE_RST;
      max_iter = MAX_ITER_RST;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_SIZE: begin
          image_size = data[SIZE_W-1:0];
        end
        CFG_MAX_ITERATIONS: begin
          max_iter = data[ITER_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function fix_t clamp_fix(longint v);
      if (v > FIX_MAX) return fix_t'(FIX_MAX);
      if (v < FIX_MIN) return fix_t'(FIX_MIN);
      return fix_t'(v);
    endfunction

    // exact product, magnitude truncated, sign applied, then clamped
    function fix_t fix_mul(fix_t a, fix_t b);
      longint ua;
      longint ub;
      longint unsigned prod;
      longint unsigned mag;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -longint'(a) : longint'(a);
      ub = (b < 0) ? -longint'(b) : longint'(b);
      prod = longint'(ua) * longint'(ub);
      mag = prod >> FRAC_BITS;
      if (mag > FIX_LIM) mag = FIX_LIM;
      if (neg) return fix_t'(-longint'(mag));
      if (mag > FIX_MAX) return fix_t'(FIX_MAX);
      return fix_t'(mag);
    endfunction

    // 2p/d truncated with FRAC_BITS fraction bits, -1 when far out of range
    function longint pix_quot(logic [PIX_W-1:0] p, longint d);
      longint n;
      n = 2 * longint'(p);
      if (n / d >= 16) return -1;
      return (n << FRAC_BITS) / d;
    endfunction

    // escape count and palette colour of one pixel
    function result_t escape_colour(pixel_t px);
      longint size;
      longint d;
      longint qx;
      longint qy;
      longint sx;
      longint sy;
      longint left;
      longint mx;
      fix_t cx;
      fix_t cy;
      fix_t zx;
      fix_t zy;
      fix_t pr;
      rgb_t col;
      result_t res;
      size = (image_size > MAX_SIZE) ? MAX_SIZE : image_size;
      d = (size < 2) ? 1 : size - 1;
      qx = pix_quot(px.x_pixel, d);
      qy = pix_quot(px.y_pixel, d);
      cx = (qx < 0) ? fix_t'(FIX_MAX) : clamp_fix(qx - 3 * (FIX_ONE / 2));
      cy = (qy < 0) ? fix_t'(FIX_MIN) : clamp_fix(FIX_ONE - qy);
      zx = '0;
      zy = '0;
      mx = max_iter;
      left = mx;
      while (left > 0) begin
        sx = fix_mul(zx, zx);
        sy = fix_mul(zy, zy);
        if (sx + sy >= 4 * FIX_ONE) break;
        pr = fix_mul(zx, zy);
        zx = clamp_fix(sx - sy + cx);
        zy = clamp_fix(2 * longint'(pr) + cy);
        left--;
      end
      if (left == 0) col = RGB_BLACK;
      else if (5 * left < 3 * mx) col = RGB_PAL_0;
      else if (20 * left < 17 * mx) col = RGB_PAL_1;
      else if (25 * left < 23 * mx) col = RGB_PAL_2;
      else if (100 * left < 97 * mx) col = RGB_PAL_3;
      else if (left < mx) col = RGB_PAL_4;
      else col = RGB_BLACK;
      res.red = col.red;
      res.green = col.green;
      res.blue = col.blue;
      res.iterations_left = ITER_W'(left);
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      expected_colours.push_back(escape_colour(px));
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_colour(result_t got);
      result_t exp_res;
      if (expected_colours.size() == 0) begin
        $display("%0t: result with no pixel pending, expected none got %h", $time, got);
        errors++;
        return;
      end
      exp_res = expected_colours.pop_front();
      compare_field("red", exp_res.red, got.red);
      compare_field("green", exp_res.green, got.green);
      compare_field("blue", exp_res.blue, got.blue);
      compare_field("iterations_left", exp_res.iterations_left, got.iterations_left);
    endfunction
  endclass

  logic clk_i;
  logic rst_n;
  logic start;
  logic busy;
  pixel_t pixel;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic result_valid;
  result_t result;
  colour_checker sb;
  int stall_cycles = 0;

  mandelbrot_pixel_colour_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_n && result_valid == 1'b1) begin
      sb.check_colour(result);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if ((start && busy == 1'b0) || result_valid == 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hand one pixel over and wait until it is taken
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    pixel_t px;
    px.x_pixel = x;
    px.y_pixel = y;
    start <= 1'b1;
    pixel <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_pixel(px);
  endtask

  // random sender gap, junk on the pixel bus meanwhile
  task automatic pause_sender(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      pixel <= pixel_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  // let every pixel finish, then write both registers
  task automatic configure(input logic [CFG_DATA_W-1:0] size_word,
                           input logic [CFG_DATA_W-1:0] iter_word);
    start <= 1'b0;
    while (sb.expected_colours.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IMAGE_SIZE;
    cfg_data <= size_word;
    @(posedge clk_i);
    sb.write_reg(CFG_IMAGE_SIZE, size_word);
    cfg_idx <= CFG_MAX_ITERATIONS;
    cfg_data <= iter_word;
    @(posedge clk_i);
    sb.write_reg(CFG_MAX_ITERATIONS, iter_word);
    cfg_we <= 1'b0;
  endtask

  // one register setting followed by random pixels, mostly inside the image
  task automatic random_segment(input int idle_pct, input int count);
    logic [CFG_DATA_W-1:0] size_word;
    logic [CFG_DATA_W-1:0] iter_word;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    int sz;
    int span;
    case ($urandom_range(5))
      0: sz = $urandom_range(16, 2);
      1: sz = $urandom_range(MAX_SIZE, 2);
      2: sz = $urandom_range(1);
      3: sz = $urandom_range(8191, MAX_SIZE);
      4: sz = $urandom_range(64, 3);
      default: sz = 512;
    endcase
    case ($urandom_range(9))
      0: iter_word = '0;
      1, 2, 3: iter_word = CFG_DATA_W'($urandom_range(10, 1));
      4, 5, 6, 7: iter_word = CFG_DATA_W'($urandom_range(64, 11));
      default: iter_word = CFG_DATA_W'($urandom_range(200, 65));
    endcase
    size_word = CFG_DATA_W'($urandom);
    size_word[SIZE_W-1:0] = sz[SIZE_W-1:0];
    configure(size_word, iter_word);
    span = (sz > MAX_SIZE) ? MAX_SIZE : ((sz < 2) ? 2 : sz);
    repeat (count) begin
      pause_sender(idle_pct);
      x = ($urandom_range(9) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(span - 1));
      y = ($urandom_range(9) == 0) ? PIX_W'($urandom) : PIX_W'($urandom_range(span - 1));
      send_pixel(x, y);
    end
  endtask

  initial begin
    int idle_pcts[3];
    idle_pcts = '{23, 54, 0};
    start = 1'b0;
    pixel = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IMAGE_SIZE;
    cfg_data = '0;
    rst_n = 1'b0;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset setting: corners, centre of the set, far outside
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd511, 12'd511);
    send_pixel(12'd255, 12'd255);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);

    // smallest legal image, single iteration, upper data bits set
    configure(16'hE002, 16'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // image side of zero and zero budget
    configure(16'd0, 16'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);

    // image side of one
    configure(16'd1, 16'd255);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);

    // image side beyond the largest, clamped
    configure(16'h1FFF, 16'd20);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2047, 12'd2048);
    send_pixel(12'd3072, 12'd1024);

    // largest image side
    configure(16'd4096, 16'd100);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2048);

    // full budget, one point inside the set
    configure(16'd3, 16'hFFFF);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2, 12'd2);

    // random phases, sender gaps light, heavy, then none
    foreach (idle_pcts[i]) begin
      repeat (5) random_segment(idle_pcts[i], 102);
    end

    // drain and finish
    start <= 1'b0;
    while (sb.expected_colours.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
